[hw/rtl/toroidal_matrix_morph_defines.svh]
// ----------------------------------------------------------------------------
// Toroidal matrix morph assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TOROIDAL_MATRIX_MORPH_DEFINES_SVH
`define TOROIDAL_MATRIX_MORPH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMM_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TMM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tmm_pkg.sv]
// ----------------------------------------------------------------------------
// Toroidal matrix morph package
// Opcodes, controller states, command and status types and fixed widths.
// ----------------------------------------------------------------------------
package tmm_pkg;

	localparam int FRAC_W   = 14;
	localparam int ONE_Q14  = 16384;
	localparam int WEIGHT_W = 16;
	localparam int CORNER_W = 29;
	localparam int PROD_W   = 45;
	localparam int ROW_W    = 3;
	localparam int COL_W    = 4;
	localparam int FB_W     = 3;
	localparam int DEPTH_W  = 16;

	typedef enum logic [2:0] {
		OP_WR_WEIGHT = 3'd0,
		OP_WR_FB     = 3'd1,
		OP_EVAL      = 3'd2,
		OP_STEP_CLK  = 3'd3,
		OP_STEP_RST  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_NEAR,
		ST_RUN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} meta_t;

	typedef struct packed {
		logic  wr_weight;
		logic  wr_fb;
		logic  setup;
		logic  near;
		logic  issue;
		meta_t item;
	} cmd_t;

	typedef struct packed {
		logic advance;
		logic pipe_empty;
	} stat_t;

endpackage

[hw/rtl/toroidal_matrix_morph.sv]
// ----------------------------------------------------------------------------
// Toroidal matrix morph
// Bilinear blend of weight matrices stored on a wrapping grid of slots.
// ----------------------------------------------------------------------------
// Write items (weight, feedback pair) and unused opcodes leave the controller
// idle and ready. An evaluate, step clock or step reset item produces
// OPERATORS*(OPERATORS+1) results (42 by default) at one per cycle while the
// output is taken, and the next item is accepted once the controller is idle
// again: the setup state computes the corner weights, the near state picks the
// nearest corner, the run state issues each matrix entry, a five-stage blend
// pipeline then drains, and the controller returns to idle. The issue rate is
// set by the single read port of each weight store copy; the weight store is
// held four times so that all four grid corners are read in the same cycle.
// Output stalls hold the whole pipeline. Stores need no clearing pass, and an
// entry must be written before an evaluation reads it.
`include "toroidal_matrix_morph_defines.svh"

module toroidal_matrix_morph import tmm_pkg::*; #(
	parameter int GRID_COLUMNS = 4,
	parameter int GRID_ROWS    = 4,
	parameter int OPERATORS    = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[3:0], row[6:4], col[9:7], weight[25:10], fb_source[28:26],
	// fb_dest[31:29], pos_x[47:32], pos_y[63:48]
	input  logic [63:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_weight[15:0], out_row[18:16], out_col[21:19], near_fb_source[24:22],
	// near_fb_dest[27:25], zero[31:28]
	output logic [31:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int XW = $clog2(GRID_COLUMNS);
	localparam int YW = $clog2(GRID_ROWS);
	localparam int KW = $clog2(OPERATORS * (OPERATORS + 1));

	cmd_t              cmd;
	stat_t             stat;
	logic [XW-1:0]     x0;
	logic [YW-1:0]     y0;
	logic [FRAC_W-1:0] fx, fy;
	logic [KW-1:0]     k;
	logic [15:0]       out_weight;
	logic [2:0]        out_row, out_col;
	logic [2:0]        near_fb_source, near_fb_dest;

	assign cfg_ready = 1'b1;

	tmm_ctrl #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS),
		.OPERATORS    (OPERATORS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.slot     (s_tdata[3:0]),
		.row      (s_tdata[6:4]),
		.col      (s_tdata[9:7]),
		.pos_x    (s_tdata[47:32]),
		.pos_y    (s_tdata[63:48]),
		.cmd      (cmd),
		.stat     (stat),
		.x0       (x0),
		.y0       (y0),
		.fx       (fx),
		.fy       (fy),
		.k        (k)
	);

	tmm_dpath #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS),
		.OPERATORS    (OPERATORS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.x0             (x0),
		.y0             (y0),
		.fx             (fx),
		.fy             (fy),
		.k              (k),
		.slot           (s_tdata[3:0]),
		.row            (s_tdata[6:4]),
		.col            (s_tdata[9:7]),
		.weight         (s_tdata[25:10]),
		.fb_source      (s_tdata[28:26]),
		.fb_dest        (s_tdata[31:29]),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_data       (cfg_data),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.out_weight     (out_weight),
		.out_row        (out_row),
		.out_col        (out_col),
		.near_fb_source (near_fb_source),
		.near_fb_dest   (near_fb_dest),
		.m_tlast        (m_tlast)
	);

	assign m_tdata = {4'b0, near_fb_dest, near_fb_source, out_col, out_row, out_weight};

	`TMM_ASSERT_HOLDS(a_ready_pipe_empty, s_tready, stat.pipe_empty, "input ready while blend pipeline busy")
	`TMM_ASSERT_NEXT(a_write_single_cycle, s_tvalid && s_tready && (s_tuser == OP_WR_WEIGHT || s_tuser == OP_WR_FB), s_tready, "write transfer did not complete in one cycle")
	`TMM_ASSERT_NEXT(a_eval_busy, s_tvalid && s_tready && s_tuser == OP_EVAL, !s_tready, "evaluate transfer did not start a run")
	`TMM_ASSERT_HOLDS(a_fb_only_last, m_tvalid && !m_tlast, m_tdata[27:22] == 6'd0, "feedback pair shown before the last transfer")

endmodule

[hw/rtl/tmm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
module tmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/tmm_ctrl.sv]
// ----------------------------------------------------------------------------
// Toroidal matrix morph controller
// Decodes input items, keeps the step position and sequences one evaluation.
// ----------------------------------------------------------------------------
module tmm_ctrl import tmm_pkg::*; #(
	parameter int GRID_COLUMNS = 4,
	parameter int GRID_ROWS    = 4,
	parameter int OPERATORS    = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [2:0]                          opcode,
	input  logic [3:0]                          slot,
	input  logic [2:0]                          row,
	input  logic [2:0]                          col,
	input  logic [15:0]                         pos_x,
	input  logic [15:0]                         pos_y,
	output cmd_t                                cmd,
	input  stat_t                               stat,
	output logic [$clog2(GRID_COLUMNS)-1:0]     x0,
	output logic [$clog2(GRID_ROWS)-1:0]        y0,
	output logic [FRAC_W-1:0]                   fx,
	output logic [FRAC_W-1:0]                   fy,
	output logic [$clog2(OPERATORS*(OPERATORS+1))-1:0] k
);

	localparam int NUM_SLOTS = GRID_COLUMNS * GRID_ROWS;
	localparam int MAT_COLS  = OPERATORS + 1;
	localparam int MAT_SIZE  = OPERATORS * MAT_COLS;
	localparam int XW        = $clog2(GRID_COLUMNS);
	localparam int YW        = $clog2(GRID_ROWS);
	localparam int KW        = $clog2(MAT_SIZE);
	localparam int RW        = $clog2(OPERATORS);
	localparam int CW        = $clog2(MAT_COLS);

	state_t         state_q, state_d;
	op_t            op;
	logic           accept;
	logic           is_eval;
	logic           wr_ok;
	logic           k_last;
	logic [XW-1:0]  x0_q, step_x_q, step_x_nx;
	logic [YW-1:0]  y0_q, step_y_q, step_y_nx;
	logic [FRAC_W-1:0] fx_q, fy_q;
	logic [XW:0]    xi, xm;
	logic [YW:0]    yi, ym;
	logic [KW-1:0]  k_q;
	logic [RW-1:0]  i_q;
	logic [CW-1:0]  j_q;

	assign op      = op_t'(opcode);
	assign accept  = s_tvalid && s_tready;
	assign is_eval = (op == OP_EVAL) || (op == OP_STEP_CLK) || (op == OP_STEP_RST);
	assign wr_ok   = (32'(slot) < NUM_SLOTS) && (32'(row) < OPERATORS) && (32'(col) < MAT_COLS);
	assign k_last  = (k_q == KW'(MAT_SIZE - 1));

	// Integer part of the position, wrapped onto the grid.
	assign xi = (XW+1)'(pos_x[15:14]);
	assign yi = (YW+1)'(pos_y[15:14]);
	assign xm = (xi >= (XW+1)'(GRID_COLUMNS)) ? xi - (XW+1)'(GRID_COLUMNS) : xi;
	assign ym = (yi >= (YW+1)'(GRID_ROWS)) ? yi - (YW+1)'(GRID_ROWS) : yi;

	assign step_x_nx = (step_x_q == XW'(GRID_COLUMNS - 1)) ? '0 : step_x_q + 1'b1;
	assign step_y_nx = (step_x_q != XW'(GRID_COLUMNS - 1)) ? step_y_q :
		((step_y_q == YW'(GRID_ROWS - 1)) ? '0 : step_y_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_x_q <= '0;
			step_y_q <= '0;
			k_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (op)
					OP_STEP_CLK: begin
						step_x_q <= step_x_nx;
						step_y_q <= step_y_nx;
					end
					OP_STEP_RST: begin
						step_x_q <= '0;
						step_y_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_NEAR) begin
				k_q <= '0;
				i_q <= '0;
				j_q <= '0;
			end else if (state_q == ST_RUN && stat.advance) begin
				k_q <= k_q + 1'b1;
				if (j_q == CW'(MAT_COLS - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (op)
				OP_EVAL: begin
					x0_q <= xm[XW-1:0];
					y0_q <= ym[YW-1:0];
					fx_q <= pos_x[FRAC_W-1:0];
					fy_q <= pos_y[FRAC_W-1:0];
				end
				OP_STEP_CLK: begin
					x0_q <= step_x_nx;
					y0_q <= step_y_nx;
					fx_q <= '0;
					fy_q <= '0;
				end
				OP_STEP_RST: begin
					x0_q <= '0;
					y0_q <= '0;
					fx_q <= '0;
					fy_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_eval) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_NEAR;
			ST_NEAR:  state_d = ST_RUN;
			ST_RUN: begin
				if (stat.advance && k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.item.row  = ROW_W'(i_q);
		cmd.item.col  = COL_W'(j_q);
		cmd.item.last = k_last;
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.wr_weight = s_tvalid && (op == OP_WR_WEIGHT) && wr_ok;
				cmd.wr_fb     = s_tvalid && (op == OP_WR_FB) && (32'(slot) < NUM_SLOTS);
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_NEAR:  cmd.near = 1'b1;
			ST_RUN:   cmd.issue = 1'b1;
			ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	assign x0 = x0_q;
	assign y0 = y0_q;
	assign fx = fx_q;
	assign fy = fy_q;
	assign k  = k_q;

endmodule

[hw/rtl/tmm_dpath.sv]
// ----------------------------------------------------------------------------
// Toroidal matrix morph datapath
// Weight and feedback stores, corner weights and the blend pipeline.
// ----------------------------------------------------------------------------
module tmm_dpath import tmm_pkg::*; #(
	parameter int GRID_COLUMNS = 4,
	parameter int GRID_ROWS    = 4,
	parameter int OPERATORS    = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cmd_t                                cmd,
	output stat_t                               stat,
	input  logic [$clog2(GRID_COLUMNS)-1:0]     x0,
	input  logic [$clog2(GRID_ROWS)-1:0]        y0,
	input  logic [FRAC_W-1:0]                   fx,
	input  logic [FRAC_W-1:0]                   fy,
	input  logic [$clog2(OPERATORS*(OPERATORS+1))-1:0] k,
	input  logic [3:0]                          slot,
	input  logic [2:0]                          row,
	input  logic [2:0]                          col,
	input  logic [WEIGHT_W-1:0]                 weight,
	input  logic [FB_W-1:0]                     fb_source,
	input  logic [FB_W-1:0]                     fb_dest,
	input  logic                                cfg_we,
	input  logic [DEPTH_W-1:0]                  cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [WEIGHT_W-1:0]                 out_weight,
	output logic [2:0]                          out_row,
	output logic [2:0]                          out_col,
	output logic [FB_W-1:0]                     near_fb_source,
	output logic [FB_W-1:0]                     near_fb_dest,
	output logic                                m_tlast
);

	localparam int NUM_SLOTS = GRID_COLUMNS * GRID_ROWS;
	localparam int MAT_COLS  = OPERATORS + 1;
	localparam int MAT_SIZE  = OPERATORS * MAT_COLS;
	localparam int XW        = $clog2(GRID_COLUMNS);
	localparam int YW        = $clog2(GRID_ROWS);
	localparam int SW        = $clog2(NUM_SLOTS);
	localparam int AW        = $clog2(NUM_SLOTS * MAT_SIZE);
	localparam int HI_W      = PROD_W - 23;
	localparam int FULL_W    = PROD_W + DEPTH_W;

	logic                   en;
	logic [DEPTH_W-1:0]     depth_q;
	logic [AW-1:0]          wr_addr;
	logic [XW-1:0]          x1;
	logic [YW-1:0]          y1;
	logic [FRAC_W:0]        gx, gy, fxe, fye;
	logic [2*FRAC_W+1:0]    cw_full [4];
	logic [SW-1:0]          slot_c [4];
	logic [SW-1:0]          slot_q [4];
	logic [AW-1:0]          base_q [4];
	logic [CORNER_W-1:0]    cw_q [4];
	logic [SW-1:0]          near_slot;
	logic [2*FB_W-1:0]      fb_rd;
	logic [AW-1:0]          rd_addr [4];
	logic [WEIGHT_W-1:0]    w_rd [4];
	logic [PROD_W-1:0]      cw_ext [4];

	logic                   v_s1, v_s2, v_s3, v_s4, m_tvalid_q;
	meta_t                  meta_s1, meta_s2, meta_s3, meta_s4;
	logic [PROD_W-1:0]      p_s2 [4];
	logic [PROD_W+1:0]      sum_w;
	logic [PROD_W-1:0]      sum_s3, sum_s4;
	logic [HI_W+DEPTH_W-1:0] hi_s4;
	logic [23+DEPTH_W-1:0]  lo_s4;
	logic [FULL_W-1:0]      full;
	logic [PROD_W-1:0]      oc;
	logic [FULL_W-43:0]     mod_val;
	logic [PROD_W-29:0]     oc_val;
	logic [WEIGHT_W-1:0]    res;

	logic [WEIGHT_W-1:0]    out_weight_q;
	logic [2:0]             out_row_q, out_col_q;
	logic [FB_W-1:0]        near_src_q, near_dst_q;
	logic                   out_last_q;

	assign en              = !m_tvalid_q || m_tready;
	assign stat.advance    = en;
	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(ONE_Q14);
		end else if (cfg_we) begin
			depth_q <= cfg_data;
		end
	end

	// Stores. Each corner has its own copy of the weights so that all four read at once.
	assign wr_addr = AW'(32'(slot) * MAT_SIZE + 32'(row) * MAT_COLS + 32'(col));

	for (genvar g = 0; g < 4; g++) begin : g_wram
		assign rd_addr[g] = base_q[g] + AW'(k);
		assign cw_ext[g]  = PROD_W'(cw_q[g]);

		tmm_ram #(
			.WIDTH (WEIGHT_W),
			.DEPTH (NUM_SLOTS * MAT_SIZE)
		) u_wram (
			.clk   (clk),
			.we    (cmd.wr_weight),
			.waddr (wr_addr),
			.wdata (weight),
			.re    (en),
			.raddr (rd_addr[g]),
			.rdata (w_rd[g])
		);
	end

	tmm_ram #(
		.WIDTH (2 * FB_W),
		.DEPTH (NUM_SLOTS)
	) u_fbram (
		.clk   (clk),
		.we    (cmd.wr_fb),
		.waddr (SW'(slot)),
		.wdata ({fb_dest, fb_source}),
		.re    (cmd.near),
		.raddr (near_slot),
		.rdata (fb_rd)
	);

	// Corner slots and bilinear corner weights in Q28.
	assign x1  = (x0 == XW'(GRID_COLUMNS - 1)) ? '0 : x0 + 1'b1;
	assign y1  = (y0 == YW'(GRID_ROWS - 1)) ? '0 : y0 + 1'b1;
	assign fxe = (FRAC_W+1)'(fx);
	assign fye = (FRAC_W+1)'(fy);
	assign gx  = (FRAC_W+1)'(ONE_Q14) - fxe;
	assign gy  = (FRAC_W+1)'(ONE_Q14) - fye;

	assign slot_c[0] = SW'(32'(y0) * GRID_COLUMNS + 32'(x0));
	assign slot_c[1] = SW'(32'(y0) * GRID_COLUMNS + 32'(x1));
	assign slot_c[2] = SW'(32'(y1) * GRID_COLUMNS + 32'(x0));
	assign slot_c[3] = SW'(32'(y1) * GRID_COLUMNS + 32'(x1));

	assign cw_full[0] = (2*FRAC_W+2)'(gx) * (2*FRAC_W+2)'(gy);
	assign cw_full[1] = (2*FRAC_W+2)'(fxe) * (2*FRAC_W+2)'(gy);
	assign cw_full[2] = (2*FRAC_W+2)'(gx) * (2*FRAC_W+2)'(fye);
	assign cw_full[3] = (2*FRAC_W+2)'(fxe) * (2*FRAC_W+2)'(fye);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			for (int g = 0; g < 4; g++) begin
				slot_q[g] <= slot_c[g];
				base_q[g] <= AW'(32'(slot_c[g]) * MAT_SIZE);
				cw_q[g]   <= cw_full[g][CORNER_W-1:0];
			end
		end
	end

	// Nearest corner, ties going to the earlier corner.
	always_comb begin
		priority if (cw_q[0] >= cw_q[1] && cw_q[0] >= cw_q[2] && cw_q[0] >= cw_q[3]) begin
			near_slot = slot_q[0];
		end else if (cw_q[1] >= cw_q[2] && cw_q[1] >= cw_q[3]) begin
			near_slot = slot_q[1];
		end else if (cw_q[2] >= cw_q[3]) begin
			near_slot = slot_q[2];
		end else begin
			near_slot = slot_q[3];
		end
	end

	// Blend pipeline: read, corner products, sum, depth products, round and saturate.
	assign sum_w = (PROD_W+2)'(p_s2[0]) + (PROD_W+2)'(p_s2[1])
		+ (PROD_W+2)'(p_s2[2]) + (PROD_W+2)'(p_s2[3]);

	assign full    = {hi_s4, 23'b0} + FULL_W'(lo_s4) + (FULL_W'(1) << 41);
	assign mod_val = full[FULL_W-1:42];
	assign oc      = sum_s4 + (PROD_W'(1) << 27);
	assign oc_val  = oc[PROD_W-1:28];

	always_comb begin
		if (meta_s4.col < COL_W'(OPERATORS)) begin
			res = (|mod_val[FULL_W-43:WEIGHT_W]) ? '1 : mod_val[WEIGHT_W-1:0];
		end else begin
			res = (|oc_val[PROD_W-29:WEIGHT_W]) ? '1 : oc_val[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1       <= cmd.issue;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			m_tvalid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= cmd.item;
			meta_s2 <= meta_s1;
			for (int g = 0; g < 4; g++) begin
				p_s2[g] <= cw_ext[g] * PROD_W'(w_rd[g]);
			end
			meta_s3 <= meta_s2;
			sum_s3  <= sum_w[PROD_W-1:0];
			meta_s4 <= meta_s3;
			sum_s4  <= sum_s3;
			hi_s4   <= (HI_W+DEPTH_W)'(sum_s3[PROD_W-1:23]) * (HI_W+DEPTH_W)'(depth_q);
			lo_s4   <= (23+DEPTH_W)'(sum_s3[22:0]) * (23+DEPTH_W)'(depth_q);
			out_weight_q <= res;
			out_row_q    <= meta_s4.row;
			out_col_q    <= meta_s4.col[2:0];
			out_last_q   <= meta_s4.last;
			near_src_q   <= meta_s4.last ? fb_rd[FB_W-1:0] : '0;
			near_dst_q   <= meta_s4.last ? fb_rd[2*FB_W-1:FB_W] : '0;
		end
	end

	assign m_tvalid       = m_tvalid_q;
	assign out_weight     = out_weight_q;
	assign out_row        = out_row_q;
	assign out_col        = out_col_q;
	assign near_fb_source = near_src_q;
	assign near_fb_dest   = near_dst_q;
	assign m_tlast        = out_last_q;

endmodule
